>>> hdl/btgb_pkg.sv
// Shared types, constants and font lookup functions for the glyph blitter.
package btgb_pkg;

    localparam int FRAME_HEIGHT = 240;
    localparam int LAST_CODE    = 126;
    localparam int GLYPH_IDX_W  = 13;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 48;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_DRAW  = 2'd1,
        OP_LOAD  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_ROWS  = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_begin;
        logic do_load;
        logic do_latch;
        logic do_stop;
        logic do_start;
        logic do_issue;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stopped;
        logic bad_char;
        logic last_row;
        logic s1_free;
    } t_ctl_sts;

    // Font size 3 behaves as the 32x16 font.
    function automatic logic [1:0] font_sel(input logic [1:0] f);
        logic [1:0] r;
        unique case (f)
            2'd0:    r = 2'd0;
            2'd1:    r = 2'd1;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] font_height(input logic [1:0] f);
        logic [5:0] r;
        unique case (font_sel(f))
            2'd0:    r = 6'd16;
            2'd1:    r = 6'd24;
            default: r = 6'd32;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] font_width(input logic [1:0] f);
        logic [4:0] r;
        unique case (font_sel(f))
            2'd0:    r = 5'd8;
            2'd1:    r = 5'd12;
            default: r = 5'd16;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] font_wmask(input logic [1:0] f);
        logic [15:0] r;
        unique case (font_sel(f))
            2'd0:    r = 16'h00FF;
            2'd1:    r = 16'h0FFF;
            default: r = 16'hFFFF;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] font_first(input logic [1:0] f);
        logic [7:0] r;
        unique case (font_sel(f))
            2'd0:    r = 8'd29;
            default: r = 8'd32;
        endcase
        return r;
    endfunction

    function automatic logic [GLYPH_IDX_W-1:0] font_base(input logic [1:0] f);
        logic [GLYPH_IDX_W-1:0] r;
        unique case (font_sel(f))
            2'd0:    r = GLYPH_IDX_W'(0);
            2'd1:    r = GLYPH_IDX_W'(1568);
            default: r = GLYPH_IDX_W'(3848);
        endcase
        return r;
    endfunction

    function automatic logic [4:0] font_lim(input logic [1:0] f);
        logic [4:0] r;
        unique case (font_sel(f))
            2'd0:    r = 5'd8;
            default: r = 5'd16;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/bitmap_text_glyph_blitter.sv
// Top level of the bitmap text glyph blitter.
//
// Slave stream (i_s_*): one item per operation, kind in i_s_tuser
//   (begin string, draw character, load glyph store word). Begin and load
//   items complete in the accept cycle and leave the block ready.
// Master stream (o_m_*): one item per glyph row of a drawn character with
//   the frame buffer pixel index, pixel mask and color; o_m_tlast marks the
//   final row of the character.
// Configuration: i_cfg_we writes the font size register (0 = 16x8,
//   1 = 24x12, 2 or 3 = 32x16); write only while the block is idle.
// Sequence: a draw item spends a setup state on range checks and address
//   setup, then issues one glyph store read per cycle while the read stage
//   can take a row; the input side stays busy until the last read issues.
//   Each row moves from the glyph store read and read stage into the output
//   register. The single glyph store read port sets the one row per cycle pace.
// Stalls: rows wait in a read stage and an output register; reads pause
//   while both are full and stalled; the next item is taken while rows drain.
// Reset: font size 0, cursor and color zero, no string open (draws emit
//   nothing until a begin). The glyph store is not cleared and must be
//   loaded before it is drawn from.
module bitmap_text_glyph_blitter #(
    parameter int FRAME_WIDTH       = 240,
    parameter int GLYPH_STORE_DEPTH = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] start_row, [15:8] start_column, [31:16] text_color,
    // [39:32] char_code, [52:40] load_address, [68:53] load_word, [71:69] zero
    input  logic [71:0] i_s_tdata,
    // [1:0] operation
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] pixel_address, [31:16] pixel_mask, [47:32] pixel_color
    output logic [47:0] o_m_tdata,
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);

    btgb_pkg::t_ctl_cmd cmd;
    btgb_pkg::t_ctl_sts sts;
    logic [15:0]        pix_addr, pix_mask, pix_color;

    // Decode the item kind and sequence glyph rows.
    btgb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_op    (i_s_tuser),
        .i_sts   (sts),
        .o_ready (o_s_tready),
        .o_cmd   (cmd)
    );

    // Hold cursor and font state, read glyph rows, drive the result stream.
    btgb_dp #(
        .FRAME_WIDTH       (FRAME_WIDTH),
        .GLYPH_STORE_DEPTH (GLYPH_STORE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start_row     (i_s_tdata[7:0]),
        .i_start_column  (i_s_tdata[15:8]),
        .i_text_color    (i_s_tdata[31:16]),
        .i_char_code     (i_s_tdata[39:32]),
        .i_load_address  (i_s_tdata[52:40]),
        .i_load_word     (i_s_tdata[68:53]),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_pixel_address (pix_addr),
        .o_pixel_mask    (pix_mask),
        .o_pixel_color   (pix_color),
        .o_last_row      (o_m_tlast)
    );

    assign o_m_tdata = {pix_color, pix_mask, pix_addr};

endmodule

>>> hdl/btgb_ram.sv
// Generic simple dual-port RAM with registered read data.
module btgb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Hold read data while no read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/btgb_ctrl.sv
// Controller state machine: item decode and row sequencing.
module btgb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_op,
    input  btgb_pkg::t_ctl_sts i_sts,
    output logic               o_ready,
    output btgb_pkg::t_ctl_cmd o_cmd
);

    btgb_pkg::t_state r_state, n_state;
    logic             accept;

    assign o_ready = (r_state == btgb_pkg::ST_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            btgb_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        btgb_pkg::OP_BEGIN: o_cmd.do_begin = 1'b1;
                        btgb_pkg::OP_LOAD:  o_cmd.do_load  = 1'b1;
                        btgb_pkg::OP_DRAW: begin
                            o_cmd.do_latch = 1'b1;
                            n_state        = btgb_pkg::ST_SETUP;
                        end
                        default: ;
                    endcase
                end
            end
            btgb_pkg::ST_SETUP: begin
                if (i_sts.stopped) begin
                    n_state = btgb_pkg::ST_IDLE;
                end else if (i_sts.bad_char) begin
                    o_cmd.do_stop = 1'b1;
                    n_state       = btgb_pkg::ST_IDLE;
                end else begin
                    o_cmd.do_start = 1'b1;
                    n_state        = btgb_pkg::ST_ROWS;
                end
            end
            btgb_pkg::ST_ROWS: begin
                if (i_sts.s1_free) begin
                    o_cmd.do_issue = 1'b1;
                    if (i_sts.last_row) begin
                        n_state = btgb_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = btgb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btgb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/btgb_dp.sv
// Datapath: cursor state, glyph store, row address generation and output stages.
module btgb_dp #(
    parameter int FRAME_WIDTH       = 240,
    parameter int GLYPH_STORE_DEPTH = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  btgb_pkg::t_ctl_cmd i_cmd,
    output btgb_pkg::t_ctl_sts o_sts,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    input  logic [7:0]         i_start_row,
    input  logic [7:0]         i_start_column,
    input  logic [15:0]        i_text_color,
    input  logic [7:0]         i_char_code,
    input  logic [12:0]        i_load_address,
    input  logic [15:0]        i_load_word,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_pixel_address,
    output logic [15:0]        o_pixel_mask,
    output logic [15:0]        o_pixel_color,
    output logic               o_last_row
);

    localparam int AW     = $clog2(GLYPH_STORE_DEPTH);
    localparam int FW_W   = $clog2(FRAME_WIDTH + 1);
    localparam int CMP_W  = (FW_W > 8) ? FW_W + 1 : 9;
    localparam int GIW    = btgb_pkg::GLYPH_IDX_W;

    logic [1:0]   r_font;
    logic [7:0]   r_cur_row, r_cur_col;
    logic [15:0]  r_color;
    logic         r_stopped;
    logic [7:0]   r_code;

    logic [GIW-1:0] r_glyph_addr;
    logic [15:0]    r_pix_addr;
    logic [4:0]     r_row_idx, r_row_max;
    logic [15:0]    r_wmask;

    logic         r_s1_valid;
    logic [15:0]  r_s1_addr, r_s1_mask, r_s1_color;
    logic         r_s1_last;

    logic         r_out_valid;
    logic [15:0]  r_out_addr, r_out_mask, r_out_color;
    logic         r_out_last;

    logic [15:0]  ram_rdata;
    logic         ram_we;
    logic         out_load;

    logic [5:0]     f_h;
    logic [4:0]     f_w;
    logic [7:0]     f_first;
    logic [CMP_W-1:0] col_lim;
    logic [8:0]     col_next;
    logic [GIW-1:0] glyph_start;
    logic [15:0]    pix_start;
    logic           bad_row, bad_col, bad_code;

    always_comb begin
        f_h      = btgb_pkg::font_height(r_font);
        f_w      = btgb_pkg::font_width(r_font);
        f_first  = btgb_pkg::font_first(r_font);
        col_lim  = CMP_W'(FRAME_WIDTH) - CMP_W'(btgb_pkg::font_lim(r_font));
        bad_row  = r_cur_row > (8'(btgb_pkg::FRAME_HEIGHT) - 8'(f_h));
        bad_col  = CMP_W'(r_cur_col) >= col_lim;
        bad_code = (r_code < f_first) || (r_code > 8'(btgb_pkg::LAST_CODE));
        col_next = 9'(r_cur_col) + 9'(f_w);
        glyph_start = btgb_pkg::font_base(r_font)
                    + GIW'(r_code - f_first) * GIW'(f_h);
        pix_start   = 16'(r_cur_row) * 16'(FRAME_WIDTH) + 16'(r_cur_col);
    end

    assign out_load = r_s1_valid && (!r_out_valid || i_ready);
    assign ram_we   = i_cmd.do_load && (32'(i_load_address) < GLYPH_STORE_DEPTH);

    assign o_sts.stopped  = r_stopped;
    assign o_sts.bad_char = bad_row || bad_col || bad_code;
    assign o_sts.last_row = (r_row_idx == r_row_max);
    assign o_sts.s1_free  = !r_s1_valid || out_load;

    btgb_ram #(
        .WIDTH (16),
        .DEPTH (GLYPH_STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_load_address)),
        .i_wdata (i_load_word),
        .i_re    (i_cmd.do_issue),
        .i_raddr (AW'(r_glyph_addr)),
        .o_rdata (ram_rdata)
    );

    // Control state: font register, cursor, stop flag, stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font      <= 2'd0;
            r_cur_row   <= 8'd0;
            r_cur_col   <= 8'd0;
            r_color     <= 16'd0;
            r_stopped   <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_font <= i_cfg_wdata;
            end
            if (i_cmd.do_begin) begin
                r_cur_row <= i_start_row;
                r_cur_col <= i_start_column;
                r_color   <= i_text_color;
                r_stopped <= 1'b0;
            end
            if (i_cmd.do_stop) begin
                r_stopped <= 1'b1;
            end
            if (i_cmd.do_start) begin
                if (col_next[8]) begin
                    r_stopped <= 1'b1;
                end else begin
                    r_cur_col <= col_next[7:0];
                end
            end
            if (i_cmd.do_issue) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_latch) begin
            r_code <= i_char_code;
        end
        if (i_cmd.do_start) begin
            r_glyph_addr <= glyph_start;
            r_pix_addr   <= pix_start;
            r_row_idx    <= 5'd0;
            r_row_max    <= 5'(f_h - 6'd1);
            r_wmask      <= btgb_pkg::font_wmask(r_font);
        end else if (i_cmd.do_issue) begin
            r_glyph_addr <= r_glyph_addr + GIW'(1);
            r_pix_addr   <= r_pix_addr + 16'(FRAME_WIDTH);
            r_row_idx    <= r_row_idx + 5'd1;
        end
        if (i_cmd.do_issue) begin
            r_s1_addr  <= r_pix_addr;
            r_s1_mask  <= r_wmask;
            r_s1_color <= r_color;
            r_s1_last  <= (r_row_idx == r_row_max);
        end
        if (out_load) begin
            r_out_addr  <= r_s1_addr;
            r_out_mask  <= ram_rdata & r_s1_mask;
            r_out_color <= r_s1_color;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_mask    = r_out_mask;
    assign o_pixel_color   = r_out_color;
    assign o_last_row      = r_out_last;

endmodule

>>> hdl/btgb_chk.sv
// Port-level assertions for the glyph blitter, bound to the top level.
module btgb_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tlast
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered after reset");

    // Begin, load and unused items finish at once and leave the block ready.
    a_quick_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser != btgb_pkg::OP_DRAW)
        |=> o_s_tready)
        else $error("non-draw item blocked the input");

endmodule

bind bitmap_text_glyph_blitter btgb_chk u_chk (.*);

>>> test/bitmap_text_glyph_blitter_test.sv
// Self-checking testbench for the bitmap text glyph blitter: directed edge cases plus random text.
module bitmap_text_glyph_blitter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_W       = 240;
    localparam int STORE_DEPTH   = 8192;
    localparam int IDLE_LIMIT    = 2000;  // cycles with no item moving on either side
    localparam int SETTLE_CYCLES = 40;    // covers a full 32-row character plus setup
    localparam logic [1:0] OP_SPARE = 2'd3;  // unused operation code, must be ignored

    // One glyph row write as it leaves the block.
    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] mask;
        logic [15:0] color;
        logic        last;
    } t_pixel_row;

    // Geometry and store placement of one font.
    typedef struct packed {
        logic [5:0]  rows;
        logic [4:0]  cols;
        logic [7:0]  first;
        logic [12:0] base;
        logic [4:0]  margin;
    } t_font_geom;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    // [7:0] start_row, [15:8] start_column, [31:16] text_color,
    // [39:32] char_code, [52:40] load_address, [68:53] load_word, [71:69] zero
    logic [71:0] i_s_tdata   = '0;
    // [1:0] operation
    logic [1:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    // [15:0] pixel_address, [31:16] pixel_mask, [47:32] pixel_color
    logic [47:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;

    // Predicted state of the block, updated on every accepted item.
    logic [1:0]  font_now;
    logic [7:0]  cursor_row;
    logic [7:0]  cursor_col;
    logic [15:0] ink_color;
    logic        text_stopped;
    logic [15:0] glyph_words [STORE_DEPTH];
    bit          glyph_loaded [STORE_DEPTH];
    t_pixel_row  rows_due [$];

    int items_sent;
    int rows_checked;
    int chars_drawn;
    int string_stops;
    int fail_count;
    int idle_cycles;
    int burst_left;
    int sink_mode;
    int sink_mode_left;
    int sink_hold;
    logic sink_level = 1'b1;

    bitmap_text_glyph_blitter #(
        .FRAME_WIDTH       (FRAME_W),
        .GLYPH_STORE_DEPTH (STORE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Font tables. Size 3 falls back to the 32x16 font.
    // ------------------------------------------------------------------
    function automatic t_font_geom glyph_geometry(input logic [1:0] fs);
        t_font_geom g;
        g.first  = 8'd32;
        g.margin = 5'd16;
        case (fs)
            2'd0: begin
                g.rows   = 6'd16;
                g.cols   = 5'd8;
                g.first  = 8'd29;
                g.base   = 13'd0;
                g.margin = 5'd8;
            end
            2'd1: begin
                g.rows = 6'd24;
                g.cols = 5'd12;
                g.base = 13'd1568;
            end
            default: begin
                g.rows = 6'd32;
                g.cols = 5'd16;
                g.base = 13'd3848;
            end
        endcase
        return g;
    endfunction

    // True when every row of this code's glyph in the current font has been loaded.
    function automatic bit glyph_ready(input logic [7:0] code);
        t_font_geom g;
        int idx;
        bit ok;
        g   = glyph_geometry(font_now);
        idx = int'(g.base) + (int'(code) - int'(g.first)) * int'(g.rows);
        ok  = 1'b1;
        for (int i = 0; i < int'(g.rows); i++)
            if (!glyph_loaded[idx + i]) ok = 1'b0;
        return ok;
    endfunction

    // True when a draw of this code would emit rows from the current state.
    function automatic bit draw_fits(input logic [7:0] code);
        t_font_geom g;
        g = glyph_geometry(font_now);
        return !text_stopped
            && int'(cursor_row) <= btgb_pkg::FRAME_HEIGHT - int'(g.rows)
            && int'(cursor_col) < FRAME_W - int'(g.margin)
            && int'(code) >= int'(g.first)
            && int'(code) <= btgb_pkg::LAST_CODE;
    endfunction

    // Pick an in-range code whose glyph is fully loaded; the first code always is.
    function automatic logic [7:0] ready_code();
        t_font_geom g;
        logic [7:0] c;
        g = glyph_geometry(font_now);
        for (int t = 0; t < 16; t++) begin
            c = 8'($urandom_range(int'(g.first), btgb_pkg::LAST_CODE));
            if (glyph_ready(c)) return c;
        end
        return g.first;
    endfunction

    // Random payload with the pad bits cleared; callers overwrite the fields they use.
    function automatic logic [71:0] noise_payload();
        logic [71:0] p;
        p[31:0]  = $urandom;
        p[63:32] = $urandom;
        p[71:64] = 8'($urandom);
        p[71:69] = 3'b000;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Predict the rows of one draw and advance the cursor.
    // ------------------------------------------------------------------
    task automatic predict_glyph_rows(input logic [7:0] code);
        t_font_geom g;
        t_pixel_row r;
        int idx;
        int next_col;
        g = glyph_geometry(font_now);
        if (text_stopped) begin
            // no string open: drop the draw silently
        end else if (!draw_fits(code)) begin
            // out of range code, row too low or column at the limit: close the string
            text_stopped = 1'b1;
            string_stops++;
        end else begin
            idx = int'(g.base) + (int'(code) - int'(g.first)) * int'(g.rows);
            for (int i = 0; i < int'(g.rows); i++) begin
                r.addr  = 16'((int'(cursor_row) + i) * FRAME_W + int'(cursor_col));
                r.mask  = glyph_words[idx + i] & 16'((1 << int'(g.cols)) - 1);
                r.color = ink_color;
                r.last  = (i == int'(g.rows) - 1);
                rows_due.push_back(r);
            end
            chars_drawn++;
            // a column that no longer fits in 8 bits closes the string after this glyph
            next_col = int'(cursor_col) + int'(g.cols);
            if (next_col > 255)
                text_stopped = 1'b1;
            else
                cursor_col = 8'(next_col);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Track accepted items and check each accepted row write against the oldest
    // prediction. Sampled at the rising edge, before the block updates.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : track_and_check
        t_pixel_row got;
        t_pixel_row want;
        if (!i_rst_n) begin
            font_now     = '0;
            cursor_row   = '0;
            cursor_col   = '0;
            ink_color    = '0;
            text_stopped = 1'b1;
        end else begin
            if (i_cfg_we) font_now = i_cfg_wdata;
            if (i_s_tvalid && o_s_tready) begin
                case (i_s_tuser)
                    btgb_pkg::OP_BEGIN: begin
                        cursor_row   = i_s_tdata[7:0];
                        cursor_col   = i_s_tdata[15:8];
                        ink_color    = i_s_tdata[31:16];
                        text_stopped = 1'b0;
                    end
                    btgb_pkg::OP_DRAW: predict_glyph_rows(i_s_tdata[39:32]);
                    btgb_pkg::OP_LOAD: begin
                        if (int'(i_s_tdata[52:40]) < STORE_DEPTH) begin
                            glyph_words[i_s_tdata[52:40]]  = i_s_tdata[68:53];
                            glyph_loaded[i_s_tdata[52:40]] = 1'b1;
                        end
                    end
                    OP_SPARE: ;  // no effect at all
                endcase
            end
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata[15:0], o_m_tdata[31:16], o_m_tdata[47:32], o_m_tlast};
                if (rows_due.size() == 0) begin
                    $error("unexpected row write: pixel_address %0d, nothing expected",
                           got.addr);
                    fail_count++;
                end else begin
                    want = rows_due.pop_front();
                    rows_checked++;
                    check_field("pixel_address", want.addr, got.addr);
                    check_field("pixel_mask", want.mask, got.mask);
                    check_field("pixel_color", want.color, got.color);
                    check_field("last_row", 16'(want.last), 16'(got.last));
                end
            end
        end
    end

    // End the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $error("no item moved for %0d cycles, %0d rows still due",
                   idle_cycles, rows_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver back-pressure: switch between always ready, coin flips, one cycle
    // in four, and alternating runs of stall and accept.
    always @(negedge i_clk) begin
        if (sink_mode_left == 0) begin
            sink_mode      = $urandom_range(0, 3);
            sink_mode_left = $urandom_range(40, 300);
        end
        sink_mode_left--;
        case (sink_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            2: i_m_tready <= (sink_mode_left % 4 == 0);
            default: begin
                if (sink_hold == 0) begin
                    sink_level = !sink_level;
                    sink_hold  = $urandom_range(1, 8);
                end
                sink_hold--;
                i_m_tready <= sink_level;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sender. Called at a falling edge; returns at the falling edge after the
    // item is accepted. Items go out in bursts with random gaps in between.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [71:0] payload);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= payload;
        items_sent++;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_begin(input logic [7:0] row, input logic [7:0] col,
                              input logic [15:0] color);
        logic [71:0] p;
        p = noise_payload();
        p[7:0]   = row;
        p[15:8]  = col;
        p[31:16] = color;
        send_item(btgb_pkg::OP_BEGIN, p);
    endtask

    task automatic send_draw(input logic [7:0] code);
        logic [71:0] p;
        logic [7:0] c;
        c = code;
        // swap in a loaded glyph rather than read store words never written
        if (draw_fits(c) && !glyph_ready(c)) c = ready_code();
        p = noise_payload();
        p[39:32] = c;
        send_item(btgb_pkg::OP_DRAW, p);
    endtask

    task automatic send_load(input logic [12:0] addr, input logic [15:0] word);
        logic [71:0] p;
        p = noise_payload();
        p[52:40] = addr;
        p[68:53] = word;
        send_item(btgb_pkg::OP_LOAD, p);
    endtask

    task automatic send_spare();
        send_item(OP_SPARE, noise_payload());
    endtask

    // Load every row of one glyph in the current font. Edge rows put an all-ones
    // word first and an all-zeros word second, so the width mask shows.
    task automatic load_glyph(input logic [7:0] code, input bit edge_rows);
        t_font_geom g;
        int idx;
        logic [15:0] word;
        g   = glyph_geometry(font_now);
        idx = int'(g.base) + (int'(code) - int'(g.first)) * int'(g.rows);
        for (int i = 0; i < int'(g.rows); i++) begin
            word = 16'($urandom);
            if (edge_rows && i == 0) word = 16'hFFFF;
            if (edge_rows && i == 1) word = 16'h0000;
            send_load(13'(idx + i), word);
        end
    endtask

    // Hold the input, drain every predicted row, then let the block go idle.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (rows_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_font(input logic [1:0] fs);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= fs;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Draws straight after reset find no open string and emit nothing; the
    // spare operation is ignored; loads hit both ends of the store.
    task automatic test_draw_before_begin();
        send_draw(8'd65);
        send_draw(8'd29);
        send_spare();
        send_load(13'h1FFF, 16'hFFFF);
        send_load(13'h0000, 16'h0000);
        send_draw(8'd126);
    endtask

    // Corners of the frame, the column and row limits, codes just outside
    // the font and a reopened string, all for one font size.
    task automatic test_font_edges(input logic [1:0] fs);
        t_font_geom g;
        logic [7:0] low_row;
        logic [7:0] right_col;
        set_font(fs);
        g         = glyph_geometry(fs);
        low_row   = 8'(btgb_pkg::FRAME_HEIGHT - int'(g.rows));
        right_col = 8'(FRAME_W - int'(g.margin) - 1);
        // size 3 reuses the 32x16 glyphs loaded for size 2
        if (fs != 2'd3) begin
            load_glyph(g.first, 1'b1);
            load_glyph(8'(btgb_pkg::LAST_CODE), 1'b1);
        end
        send_begin(8'd0, 8'd0, 16'hFFFF);
        send_draw(g.first);
        send_draw(8'(btgb_pkg::LAST_CODE));
        // last spot that fits; the following glyph hits the column limit
        send_begin(low_row, right_col, 16'h0000);
        send_draw(8'(btgb_pkg::LAST_CODE));
        send_draw(g.first);
        send_draw(g.first);
        // one row too low, then the column right at the limit
        send_begin(low_row + 8'd1, 8'd0, 16'h5AA5);
        send_draw(g.first);
        send_begin(8'd0, right_col + 8'd1, 16'hA55A);
        send_draw(g.first);
        send_begin(8'd239, 8'd239, 16'h0F0F);
        send_draw(g.first);
        // codes just below and just above the font, and the top byte value
        send_begin(8'd100, 8'd16, 16'h1234);
        send_draw(g.first - 8'd1);
        send_draw(g.first);
        send_begin(8'd8, 8'd40, 16'h8001);
        send_draw(8'(btgb_pkg::LAST_CODE + 1));
        send_begin(8'd8, 8'd40, 16'h7FFE);
        send_draw(8'd255);
    endtask

    // Mostly short strings of loaded glyphs at random positions; the rest are
    // fresh glyph loads and stray items of any kind.
    task automatic test_random_text(input logic [1:0] fs, input int n_items);
        t_font_geom g;
        int stop_at;
        int pick;
        set_font(fs);
        g       = glyph_geometry(fs);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_begin(($urandom_range(0, 9) < 7)
                               ? 8'($urandom_range(0, btgb_pkg::FRAME_HEIGHT - int'(g.rows)))
                               : 8'($urandom_range(0, 239)),
                           ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 120))
                                                      : 8'($urandom_range(0, 239)),
                           16'($urandom));
                repeat ($urandom_range(1, 8)) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                        send_draw(ready_code());
                    else if (pick < 88)
                        send_draw(($urandom_range(0, 1) == 0)
                                      ? 8'($urandom_range(0, int'(g.first) - 1))
                                      : 8'($urandom_range(btgb_pkg::LAST_CODE + 1, 255)));
                    else if (pick < 94)
                        send_spare();
                    else
                        send_load(13'($urandom), 16'($urandom));
                end
            end else if (pick < 75) begin
                load_glyph(8'($urandom_range(int'(g.first), btgb_pkg::LAST_CODE)), 1'b0);
            end else begin
                case ($urandom_range(0, 3))
                    0: send_begin(8'($urandom_range(0, 239)), 8'($urandom_range(0, 239)),
                                  16'($urandom));
                    1: send_draw(8'($urandom));
                    2: send_load(13'($urandom), 16'($urandom));
                    default: send_spare();
                endcase
            end
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_draw_before_begin();
        for (int f = 0; f < 4; f++)
            test_font_edges(2'(f));

        test_random_text(2'd2, 46);
        test_random_text(2'd0, 46);
        test_random_text(2'd1, 46);
        test_random_text(2'd3, 46);
        test_random_text(2'd0, 46);

        settle();
        $display("Sent %0d items over font sizes 0 to 3: %0d characters drawn, %0d cut short.",
                 items_sent, chars_drawn, string_stops);
        $display("Checked %0d row writes for address, mask, color and last-row flag.",
                 rows_checked);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
